FILE: rtl/core/mtpc_pkg.sv
// Package for the trading-profit-with-cooldown block: field widths, limits,
// and the cooldown clamp function. No dependencies.
package mtpc_pkg;

  localparam int PRICE_W    = 10;
  localparam int PROFIT_W   = 22;
  localparam int HOLD_W     = 23;
  localparam int SUM_W      = 24;
  localparam int CD_W       = 5;
  localparam int DAY_W      = 13;

  localparam int MAX_COOLDOWN = 16;
  localparam int HIST_AW      = $clog2(MAX_COOLDOWN);
  localparam int HIST_DEPTH   = 1 << HIST_AW;

  localparam logic [PRICE_W-1:0]  PRICE_LIMIT = PRICE_W'(1000);
  localparam logic [DAY_W-1:0]    DAY_MAX     = {DAY_W{1'b1}};
  localparam logic [PROFIT_W-1:0] PROFIT_MAX  = {PROFIT_W{1'b1}};
  localparam logic [CD_W-1:0]     CD_RESET    = CD_W'(1);

  typedef logic [PRICE_W-1:0]  price_t;
  typedef logic [PROFIT_W-1:0] profit_t;
  typedef logic [CD_W-1:0]     cd_t;

  // Result item as held in the output stage
  typedef struct packed {
    profit_t best_profit;
    logic    saturated;
  } result_t;

  // Cooldown actually used: zero reads as one, large values clamp
  function automatic cd_t eff_cooldown(input cd_t cd);
    cd_t r;
    r = cd;
    if (r < CD_W'(1)) r = CD_W'(1);
    if (r > CD_W'(MAX_COOLDOWN)) r = CD_W'(MAX_COOLDOWN);
    return r;
  endfunction

endpackage

FILE: rtl/core/mtpc_if.sv
// Valid/ready channel interfaces for the price input, the result output and
// the cooldown configuration write. Depends on mtpc_pkg.
interface mtpc_in_if;
  import mtpc_pkg::*;
  logic   valid;
  logic   ready;
  price_t price;
  logic   first_day;
  modport source (output valid, output price, output first_day, input ready);
  modport sink   (input valid, input price, input first_day, output ready);
endinterface

interface mtpc_out_if;
  import mtpc_pkg::*;
  logic    valid;
  logic    ready;
  profit_t best_profit;
  logic    saturated;
  modport source (output valid, output best_profit, output saturated, input ready);
  modport sink   (input valid, input best_profit, input saturated, output ready);
endinterface

interface mtpc_cfg_if;
  import mtpc_pkg::*;
  logic valid;
  logic ready;
  cd_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/max_trade_profit_with_cooldown_top.sv
// Top level of the trading-profit-with-cooldown engine: three-state profit
// recurrence with a circular history RAM. Depends on mtpc_pkg and mtpc_if.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid & ready    price[9:0], first_day
//   out_ch    out  valid & ready    best_profit[21:0], saturated
//   cfg_ch    in   valid & ready    data[4:0] (cooldown_days)
//
// One transaction per cycle while input ready is high: the recurrence closes
// combinationally on the state registers; the history RAM read is registered
// at the address the next day needs. Results land in a two-entry output stage;
// it keeps input ready high while one result waits; input ready drops only
// when both entries are full. Synchronous active-low reset, no clearing pass:
// history entries are read only after the current sequence has written them.
module max_trade_profit_with_cooldown_top (
  input  logic       clk,
  input  logic       rst_n,
  mtpc_in_if.sink    in_ch,
  mtpc_out_if.source out_ch,
  mtpc_cfg_if.sink   cfg_ch
);
  import mtpc_pkg::*;

  // State registers
  cd_t                      cd_r;
  logic signed [HOLD_W-1:0] hold_r, hold_nxt;
  profit_t                  sold_r, sold_nxt;
  profit_t                  free_r, free_nxt;
  logic [DAY_W-1:0]         day_r, day_nxt;
  logic                     sat_r, sat_nxt;
  logic [HIST_AW-1:0]       wp_r, wp_nxt;

  // History RAM and its registered read data
  profit_t                  hist_mem [HIST_DEPTH];
  profit_t                  rd_data_r;
  logic [HIST_AW-1:0]       rd_addr;

  // Output stage
  logic                     out_valid_r, skid_valid_r;
  result_t                  out_data_r, skid_data_r;
  result_t                  res;

  logic                     in_acc, cfg_acc;
  cd_t                      cd_nxt, cd_use, cd_next_use;
  price_t                   p;
  logic                     start;
  logic signed [SUM_W-1:0]  hold_ext, free_ext, sold_ext, p_ext, nh, s, past_ext;
  profit_t                  past;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid & cfg_ch.ready;
  assign in_ch.ready  = ~skid_valid_r;
  assign in_acc       = in_ch.valid & in_ch.ready;

  assign cd_nxt      = cfg_acc ? cfg_ch.data : cd_r;
  assign cd_use      = eff_cooldown(cd_r);
  assign cd_next_use = eff_cooldown(cd_nxt);

  // Next day reads the entry cd days behind its write pointer
  assign wp_nxt  = in_acc ? wp_r + HIST_AW'(1) : wp_r;
  assign rd_addr = HIST_AW'({1'b0, wp_nxt} - (HIST_AW+1)'(cd_next_use));

  // Cooldown of one means yesterday's sold value, which is the register
  assign past = (cd_use == CD_W'(1)) ? sold_r : rd_data_r;

  // Day recurrence
  always_comb begin
    p        = (in_ch.price > PRICE_LIMIT) ? PRICE_LIMIT : in_ch.price;
    start    = in_ch.first_day | (day_r == '0);
    hold_ext = SUM_W'(hold_r);
    free_ext = $signed({{(SUM_W-PROFIT_W){1'b0}}, free_r});
    sold_ext = $signed({{(SUM_W-PROFIT_W){1'b0}}, sold_r});
    past_ext = $signed({{(SUM_W-PROFIT_W){1'b0}}, past});
    p_ext    = $signed({{(SUM_W-PRICE_W){1'b0}}, p});
    nh       = free_ext - p_ext;
    s        = hold_ext + p_ext;
    hold_nxt = hold_r;
    sold_nxt = sold_r;
    free_nxt = free_r;
    day_nxt  = day_r;
    sat_nxt  = sat_r;
    if (in_acc) begin
      if (start) begin
        hold_nxt = HOLD_W'(-p_ext);
        sold_nxt = '0;
        free_nxt = '0;
        sat_nxt  = 1'b0;
        day_nxt  = DAY_W'(1);
      end else begin
        if (nh < hold_ext) nh = hold_ext;
        if (s > $signed({{(SUM_W-PROFIT_W){1'b0}}, PROFIT_MAX})) begin
          s       = $signed({{(SUM_W-PROFIT_W){1'b0}}, PROFIT_MAX});
          sat_nxt = 1'b1;
        end
        if (s < sold_ext) s = sold_ext;
        hold_nxt = HOLD_W'(nh);
        sold_nxt = PROFIT_W'(s);
        if ((day_r > DAY_W'(cd_use)) && (past_ext > free_ext)) free_nxt = past;
        if (day_r < DAY_MAX) day_nxt = day_r + DAY_W'(1);
      end
    end
    res.best_profit = sold_nxt;
    res.saturated   = sat_nxt;
  end

  // State and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r   <= CD_RESET;
      hold_r <= '0;
      sold_r <= '0;
      free_r <= '0;
      day_r  <= '0;
      sat_r  <= 1'b0;
      wp_r   <= '0;
    end else begin
      cd_r   <= cd_nxt;
      hold_r <= hold_nxt;
      sold_r <= sold_nxt;
      free_r <= free_nxt;
      day_r  <= day_nxt;
      sat_r  <= sat_nxt;
      wp_r   <= wp_nxt;
    end
  end

  // History RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_acc) hist_mem[wp_r] <= sold_nxt;
    rd_data_r <= hist_mem[rd_addr];
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end else if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_profit = out_data_r.best_profit;
  assign out_ch.saturated   = out_data_r.saturated;

endmodule

FILE: sim/tb_max_trade_profit_with_cooldown_top.sv
// Self-checking testbench for max_trade_profit_with_cooldown_top: a directed table, one
// long sequence and random phases, scored by a local profit model or typed expectations.
// Depends on mtpc_pkg, mtpc_if and the top-level RTL.
module tb_max_trade_profit_with_cooldown_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mtpc_pkg::*;

  localparam int LONG_DAYS   = 255;  // one long run of buy/sell round trips
  localparam int PHASE_DAYS  = 96;
  localparam int N_PHASES    = 9;
  localparam int LONG_STALL  = 64;
  localparam int IDLE_TAIL   = 8;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [0:0] {ROW_DAY, ROW_CFG} row_kind_t;

  // One directed step: a price transaction or a cooldown write
  typedef struct {
    row_kind_t   kind;
    int unsigned value;
    bit          first;
    bit          typed;
    int unsigned want_profit;
    bit          want_sat;
  } plan_row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } day_tag_t;

  localparam int N_DIRECTED = 27;
  plan_row_t directed_plan [0:N_DIRECTED-1] = '{
    '{ROW_DAY,  500, 0, 1, 0, 0},  // nothing started yet: taken as a first day
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_DAY, 1023, 0, 0, 0, 0},  // above range, clamps to the limit
    '{ROW_DAY,    0, 0, 0, 0, 0},
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_DAY, 1023, 1, 1, 0, 0},  // restart with an oversized price
    '{ROW_DAY,    0, 0, 0, 0, 0},
    '{ROW_DAY, 1001, 0, 0, 0, 0},
    '{ROW_CFG,    0, 0, 0, 0, 0},  // zero cooldown behaves as one
    '{ROW_DAY,    0, 0, 0, 0, 0},
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_DAY,  512, 0, 0, 0, 0},
    '{ROW_CFG,   31, 0, 0, 0, 0},  // all ones, clamps to max cooldown
    '{ROW_DAY,    0, 1, 1, 0, 0},
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_DAY,    0, 0, 0, 0, 0},
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_CFG,   17, 0, 0, 0, 0},  // just above max cooldown
    '{ROW_DAY, 1000, 1, 1, 0, 0},
    '{ROW_DAY,    0, 0, 0, 0, 0},
    '{ROW_DAY,  511, 0, 0, 0, 0},
    '{ROW_CFG,   16, 0, 0, 0, 0},
    '{ROW_DAY,    0, 1, 1, 0, 0},
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_DAY, 1000, 1, 1, 0, 0},  // restart in the middle of a sequence
    '{ROW_DAY, 1000, 0, 0, 0, 0},
    '{ROW_CFG,    1, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mtpc_in_if  in_ch();
  mtpc_out_if out_ch();
  mtpc_cfg_if cfg_ch();

  max_trade_profit_with_cooldown_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Profit model state
  logic signed [HOLD_W-1:0] hold_v;
  profit_t                  sold_v;
  profit_t                  free_v;
  profit_t                  sold_hist [MAX_COOLDOWN];
  logic [DAY_W-1:0]         seq_day;
  logic                     sat_v;
  cd_t                      cd_reg;

  result_t  profit_q [$];   // expected results, oldest first
  day_tag_t day_tags [$];   // per offered transaction: typed expectation or not

  int  errors;
  int  days_in;
  int  results_out;
  int  sat_seen;
  int  cfg_writes;
  int  burst_left;
  bit  steady;
  result_t got;
  day_tag_t tag;

  // Next day of the three-state recurrence; updates the model state
  function automatic result_t next_best_profit(input price_t raw, input logic fd);
    int p, nh, ns, nf, cd;
    result_t r;
    p = (raw > PRICE_LIMIT) ? int'(PRICE_LIMIT) : int'(raw);
    if (fd || seq_day == '0) begin
      hold_v  = HOLD_W'(-p);
      sold_v  = '0;
      free_v  = '0;
      sat_v   = 1'b0;
      seq_day = DAY_W'(1);
      foreach (sold_hist[k]) sold_hist[k] = '0;
    end else begin
      cd = int'(cd_reg);
      if (cd < 1) cd = 1;
      if (cd > MAX_COOLDOWN) cd = MAX_COOLDOWN;
      nh = int'(free_v) - p;
      if (nh < int'(hold_v)) nh = int'(hold_v);
      ns = int'(hold_v) + p;
      if (ns > int'(PROFIT_MAX)) begin
        ns    = int'(PROFIT_MAX);
        sat_v = 1'b1;
      end
      if (ns < int'(sold_v)) ns = int'(sold_v);
      nf = int'(free_v);
      // buying again only once the sale from cd days back is in the past
      if (int'(seq_day) > cd && int'(sold_hist[cd-1]) > nf) nf = int'(sold_hist[cd-1]);
      hold_v = HOLD_W'(nh);
      sold_v = PROFIT_W'(ns);
      free_v = PROFIT_W'(nf);
      if (seq_day != DAY_MAX) seq_day = seq_day + 1'b1;
    end
    for (int k = MAX_COOLDOWN - 1; k > 0; k--) sold_hist[k] = sold_hist[k-1];
    sold_hist[0] = sold_v;
    r.best_profit = sold_v;
    r.saturated   = sat_v;
    return r;
  endfunction

  // Monitor: config writes, accepted days and returned results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) cd_reg = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        tag = day_tags.pop_front();
        got = next_best_profit(in_ch.price, in_ch.first_day);
        profit_q.push_back(tag.typed ? tag.want : got);
        days_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_out++;
        if (out_ch.saturated) sat_seen++;
        if (profit_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: result %0d arrived with nothing expected (profit=%0d sat=%0b)",
                     results_out, out_ch.best_profit, out_ch.saturated);
        end else begin
          got = profit_q.pop_front();
          if (out_ch.best_profit !== got.best_profit || out_ch.saturated !== got.saturated)
          begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("ERROR: result %0d expected profit=%0d sat=%0b, got profit=%0d sat=%0b",
                       results_out, got.best_profit, got.saturated,
                       out_ch.best_profit, out_ch.saturated);
          end
        end
      end
    end
  end

  // Result sink: changing stall patterns plus two long hold-offs to back up the input
  initial begin : result_sink
    int mode, span, stall_left, taken, holds_done;
    mode = 0;
    span = 0;
    stall_left = 0;
    taken = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (span == 0) begin
        mode = $urandom_range(3, 0);
        span = $urandom_range(200, 20);
      end
      span--;
      if (stall_left == 0 && ((holds_done == 0 && taken >= 100) ||
                              (holds_done == 1 && taken >= 700))) begin
        stall_left = LONG_STALL;
        holds_done++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(1, 0) == 0);
          2: out_ch.ready <= ($urandom_range(9, 0) != 0);
          default: out_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // Offer one day; bursts of random length separated by random gaps
  task automatic offer_day(input price_t p, input logic fd, input bit typed,
                           input result_t want);
    int gap;
    day_tag_t t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      gap = steady ? 0 : (($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    t.typed = typed;
    t.want  = want;
    day_tags.push_back(t);
    in_ch.valid     <= 1'b1;
    in_ch.price     <= p;
    in_ch.first_day <= fd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (profit_q.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic set_cooldown(input cd_t v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Random trading: mostly flagged sequences, some carried over or broken by stray restarts
  task automatic run_trading_phase(input int n_days);
    int left, seq_len, shape, period, i;
    price_t p;
    logic fd;
    left = n_days;
    steady = ($urandom_range(3, 0) == 0);
    fd = ($urandom_range(3, 0) != 0);
    while (left > 0) begin
      seq_len = ($urandom_range(7, 0) == 0) ? $urandom_range(90, 30) : $urandom_range(24, 1);
      shape = $urandom_range(1, 0);
      period = $urandom_range(12, 2);
      for (i = 0; i < seq_len && left > 0; i++) begin
        case ($urandom_range(9, 0))
          0: p = '0;
          1: p = PRICE_LIMIT;
          2: p = price_t'($urandom_range(1023, 1001));
          default: begin
            if (shape == 0)
              p = price_t'($urandom_range(1000, 0));
            else if ((i % period) < period / 2)
              p = price_t'($urandom_range(300, 0));
            else
              p = price_t'($urandom_range(1000, 700));
          end
        endcase
        if (i > 0) fd = ($urandom_range(39, 0) == 0);
        offer_day(p, fd, 1'b0, '0);
        left--;
      end
      fd = ($urandom_range(9, 0) != 0);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    result_t want;
    price_t  p;
    cd_t     phase_cd [N_PHASES];
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.price     <= '0;
    in_ch.first_day <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    errors = 0;
    days_in = 0;
    results_out = 0;
    sat_seen = 0;
    cfg_writes = 0;
    burst_left = 0;
    steady = 1'b0;
    // model state after reset
    cd_reg  = CD_RESET;
    hold_v  = '0;
    sold_v  = '0;
    free_v  = '0;
    seq_day = '0;
    sat_v   = 1'b0;
    foreach (sold_hist[k]) sold_hist[k] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        set_cooldown(cd_t'(directed_plan[r].value));
      end else begin
        want.best_profit = PROFIT_W'(directed_plan[r].want_profit);
        want.saturated   = directed_plan[r].want_sat;
        offer_day(price_t'(directed_plan[r].value), directed_plan[r].first,
                  directed_plan[r].typed, want);
      end
    end

    // Long sequence: buy at zero, sell at the limit, cool down
    set_cooldown(CD_RESET);
    for (int d = 0; d < LONG_DAYS; d++) begin
      case (d % 3)
        0: p = '0;
        1: p = PRICE_LIMIT;
        default: p = price_t'($urandom_range(1000, 0));
      endcase
      offer_day(p, d == 0, 1'b0, '0);
    end
    want = '0;
    offer_day(PRICE_LIMIT, 1'b1, 1'b1, want);  // restart after the long run

    // Random phases over a spread of cooldown settings
    phase_cd = '{cd_t'(MAX_COOLDOWN), cd_t'(2), cd_t'(0), cd_t'(31), cd_t'(17), CD_RESET,
                 cd_t'($urandom_range(31, 0)), cd_t'($urandom_range(16, 1)), cd_t'(9)};
    foreach (phase_cd[ph]) begin
      set_cooldown(phase_cd[ph]);
      run_trading_phase(PHASE_DAYS);
    end

    wait_idle();
    $display("Run covered %0d days, %0d results, %0d cooldown writes, %0d saturated results.",
             days_in, results_out, cfg_writes, sat_seen);
    $display("Mismatches: %0d, results still expected: %0d", errors, profit_q.size());
    if (errors == 0 && profit_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3000000;
    $display("Timeout: %0d days accepted, %0d results received", days_in, results_out);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
